[hdl/wsc_pkg.sv]
package wsc_pkg;

  localparam int SampleBits = 16;
  localparam int CfgLenW    = 11;
  localparam int ThrW       = 16;
  localparam int CountW     = 32;
  localparam int CfgDataW   = 16;
  localparam int CfgIdxW    = 2;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = 1;
  localparam int QCntW      = 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegWindowLen = 2'd0,
    RegThreshold = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [SampleBits-1:0] sample;
    logic                  last;
  } in_item_t;

  typedef struct packed {
    logic              window_full;
    logic              meets;
    logic [CountW-1:0] match_count;
    logic              final_res;
  } out_item_t;

  // Classified sample handed from the front to the back.
  typedef struct packed {
    logic                  sub;
    logic                  full;
    logic                  last;
    logic [SampleBits-1:0] sample;
    logic [SampleBits-1:0] old_sample;
  } mid_item_t;

  typedef struct packed {
    logic      valid;
    mid_item_t item;
  } mid_xfer_t;

endpackage

[hdl/wsc_front.sv]
module wsc_front import wsc_pkg::*; #(
  parameter int MaxWindow = 1024,
  parameter int PtrW      = 10,
  parameter int LenW      = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clr_i,
  input  logic [LenW-1:0] len_i,
  input  logic            push_i,
  input  in_item_t        in_i,
  output logic            ready_o,
  input  logic            q_ready_i,
  output mid_xfer_t       out_o
);

  localparam int IdxW = LenW + 1;

  logic [SampleBits-1:0] mem_q [MaxWindow];
  logic [SampleBits-1:0] rd_q;

  logic [PtrW-1:0] wp_q;
  logic [LenW-1:0] fill_q;
  logic            s1_valid_q;
  logic            sub_q, full_q, last_q;
  logic [SampleBits-1:0] sample_q;

  logic            acc;
  logic            sub;
  logic [LenW-1:0] fill_nxt;
  logic [IdxW-1:0] wp_x, len_x, old_x;
  logic [PtrW-1:0] old_idx, wp_nxt;

  assign ready_o = !s1_valid_q || q_ready_i;
  assign acc     = push_i && ready_o;

  // Oldest sample of the window sits len entries behind the write pointer.
  always_comb begin
    wp_x     = IdxW'(wp_q);
    len_x    = IdxW'(len_i);
    old_x    = (wp_x >= len_x) ? (wp_x - len_x) : (wp_x + IdxW'(MaxWindow) - len_x);
    old_idx  = old_x[PtrW-1:0];
    wp_nxt   = (wp_q == PtrW'(MaxWindow - 1)) ? '0 : wp_q + 1'b1;
    sub      = (fill_q >= len_i);
    fill_nxt = sub ? fill_q : fill_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      mem_q[wp_q] <= in_i.sample;
      rd_q        <= mem_q[old_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      fill_q     <= '0;
      s1_valid_q <= 1'b0;
    end else if (clr_i) begin
      wp_q       <= '0;
      fill_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid_q <= 1'b1;
        wp_q       <= in_i.last ? '0 : wp_nxt;
        fill_q     <= in_i.last ? '0 : fill_nxt;
      end else if (q_ready_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      sub_q    <= sub;
      full_q   <= (fill_nxt >= len_i);
      last_q   <= in_i.last;
      sample_q <= in_i.sample;
    end
  end

  always_comb begin
    out_o.valid           = s1_valid_q;
    out_o.item.sub        = sub_q;
    out_o.item.full       = full_q;
    out_o.item.last       = last_q;
    out_o.item.sample     = sample_q;
    out_o.item.old_sample = rd_q;
  end

endmodule

[hdl/wsc_queue.sv]
module wsc_queue import wsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mid_xfer_t push_i,
  output logic      ready_o,
  input  logic      pop_i,
  output mid_xfer_t head_o
);

  mid_item_t        slots_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign ready_o     = (cnt_q != QCntW'(QueueDepth));
  assign do_push     = push_i.valid && ready_o;
  assign do_pop      = pop_i && (cnt_q != '0);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = slots_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= push_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[hdl/wsc_back.sv]
module wsc_back import wsc_pkg::*; #(
  parameter int LenW = 11,
  parameter int SumW = 27
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clr_i,
  input  logic [LenW-1:0] len_i,
  input  logic [ThrW-1:0] thr_i,
  input  mid_xfer_t       head_i,
  output logic            q_pop_o,
  input  logic            pop_i,
  output logic            out_valid_o,
  output out_item_t       out_o
);

  localparam int CmpW = LenW + ThrW;

  logic [CmpW-1:0]   target_q;
  logic [SumW-1:0]   sum_q, sum_n;
  logic [CountW-1:0] cnt_q, cnt_n;
  logic              ov_q;
  out_item_t         out_q;
  logic              take, meets;

  assign take    = head_i.valid && (!ov_q || pop_i);
  assign q_pop_o = take;

  // Target loads each cycle; user must move config only when idle.
  always_ff @(posedge clk_i) begin
    target_q <= CmpW'(len_i) * CmpW'(thr_i);
  end

  always_comb begin
    sum_n = sum_q + SumW'(head_i.item.sample)
          - (head_i.item.sub ? SumW'(head_i.item.old_sample) : '0);
    meets = head_i.item.full && (CmpW'(sum_n) >= target_q);
    cnt_n = (meets && (cnt_q != '1)) ? cnt_q + 1'b1 : cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else if (clr_i) begin
      sum_q <= '0;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (take) begin
        ov_q  <= 1'b1;
        sum_q <= head_i.item.last ? '0 : sum_n;
        cnt_q <= head_i.item.last ? '0 : cnt_n;
      end else if (pop_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q.window_full <= head_i.item.full;
      out_q.meets       <= meets;
      out_q.match_count <= cnt_n;
      out_q.final_res   <= head_i.item.last;
    end
  end

  assign out_valid_o = ov_q;
  assign out_o       = out_q;

endmodule

[hdl/window_sum_threshold_counter.sv]
// Sliding-window sum threshold counter.
//
// Input side is a queue write port: a sample transaction (sample, last) is
// taken on a clock edge with push high and full low. Result side is a queue
// read port: while empty is low the oldest result sits on out_data_o and it
// is consumed on an edge with pop high. Every sample gives exactly one result.
// Config: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 = window length, 1 = threshold); write only while the block is drained.
// A window length write also restarts the stream.
//
// An accepted sample passes the front stage register, the queue and the output
// register. Throughput: one sample per cycle while full stays low, set by the
// single write/read delay line RAM port pair and the one add/subtract/compare
// in the back end. When pop stalls, the output register, the 2-entry queue
// and the front stage fill up in turn before full rises; nothing is dropped.
// Reset clears pointers, fill count, sum and match count; window length
// returns to 1 and threshold to 0. The delay line RAM is not cleared: an entry
// is only used once the window has filled in the current stream.
module window_sum_threshold_counter import wsc_pkg::*; #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  in_item_t            in_data_i,
  output logic                empty,
  input  logic                pop,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int PtrW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LenW = $clog2(MAX_WINDOW + 1);
  localparam int SumW = SampleBits + LenW;

  logic [CfgLenW-1:0] len_q;
  logic [ThrW-1:0]    thr_q;
  logic [LenW-1:0]    eff_len;
  logic               clr;

  mid_xfer_t front_xfer, q_head;
  logic      front_ready, q_ready, q_pop, out_valid;

  // Config registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= CfgLenW'(1);
      thr_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegWindowLen: len_q <= cfg_data_i[CfgLenW-1:0];
        RegThreshold: thr_q <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // A new window length restarts the stream on both halves.
  assign clr = cfg_we_i && (cfg_idx_i == RegWindowLen);

  // Zero length acts as one, oversize lengths clamp to the delay line depth.
  always_comb begin
    if (len_q == '0) begin
      eff_len = LenW'(1);
    end else if (32'(len_q) > 32'(MAX_WINDOW)) begin
      eff_len = LenW'(MAX_WINDOW);
    end else begin
      eff_len = LenW'(len_q);
    end
  end

  wsc_front #(
    .MaxWindow (MAX_WINDOW),
    .PtrW      (PtrW),
    .LenW      (LenW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (clr),
    .len_i     (eff_len),
    .push_i    (push),
    .in_i      (in_data_i),
    .ready_o   (front_ready),
    .q_ready_i (q_ready),
    .out_o     (front_xfer)
  );

  wsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_xfer),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .head_o  (q_head)
  );

  wsc_back #(
    .LenW (LenW),
    .SumW (SumW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (clr),
    .len_i       (eff_len),
    .thr_i       (thr_q),
    .head_i      (q_head),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .out_o       (out_data_o)
  );

  assign full  = !front_ready;
  assign empty = !out_valid;

  // Backpressure only when the front stage is loaded and the queue is full.
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> (front_xfer.valid && !q_ready))
    else $error("full raised without a stalled front stage");

  // A handoff into the queue must leave an item at its head.
  a_queue_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_xfer.valid && q_ready && !clr) |=> q_head.valid)
    else $error("queue lost a pushed transaction");

  // A qualifying window is always a full one.
  a_meets_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (!out_data_o.meets || out_data_o.window_full))
    else $error("meets set on a window that is not full");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import wsc_pkg::*;

  localparam int MaxWindow   = 1024;
  localparam int CycleLimit  = 400000;
  localparam int RandomItems = 150;
  localparam int MaxReports  = 10;
  localparam int DrainCycles = 4;    // slack after the last predicted result
  localparam int NearSpread  = 512;  // sample spread around threshold in near mode
  localparam int MaxStream   = 400;  // cap on random stream length

  // Register indexes the block does not decode; writes must be ignored.
  localparam logic [CfgIdxW-1:0] RegSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpare3 = 2'd3;

  // How random samples are drawn.
  typedef enum int {
    SmpUniform,
    SmpNearThr,
    SmpRails
  } smp_mode_e;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every driven signal starts at a known value.
  // ---------------------------------------------------------------------------
  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                push     = 1'b0;
  logic                full;
  in_item_t            in_data  = '0;
  logic                empty;
  logic                pop      = 1'b0;
  out_item_t           out_data;
  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  window_sum_threshold_counter #(
    .MAX_WINDOW(MaxWindow)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_data_i (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data_o(out_data),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Window predictor: own copy of the sample history, running sum and tally.
  // ---------------------------------------------------------------------------
  logic [SampleBits-1:0] hist_mem [MaxWindow];
  logic [9:0]            hist_wr_ptr = '0;
  logic [CfgLenW-1:0]    hist_fill   = '0;
  logic [26:0]           win_sum     = '0;
  logic [CountW-1:0]     match_tally = '0;
  logic [CfgLenW-1:0]    len_reg     = 11'd1;   // reset values of the registers
  logic [ThrW-1:0]       thr_reg     = '0;

  out_item_t expect_q [$];   // predicted results, oldest first
  int        mismatches = 0;
  int        cycle_cnt  = 0;

  // Idle controls shared by the tests and the two handshake drivers.
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_hold    = 0;        // one-shot long pop hold-off, in cycles

  // Window length in use: zero acts as one, anything past the line depth clamps.
  function automatic int eff_len();
    if (len_reg == '0) return 1;
    if (len_reg > MaxWindow) return MaxWindow;
    return int'(len_reg);
  endfunction

  function automatic void restart_window();
    hist_wr_ptr = '0;
    hist_fill   = '0;
    win_sum     = '0;
    match_tally = '0;
  endfunction

  // Advance the window by one sample and return the result it produces.
  function automatic out_item_t advance_window(in_item_t item);
    int                 len;
    longint unsigned    target;
    out_item_t          res;
    len = eff_len();
    // Drop the sample leaving the window; it was written earlier in this stream.
    if (int'(hist_fill) >= len)
      win_sum = win_sum - hist_mem[(int'(hist_wr_ptr) + MaxWindow - len) % MaxWindow];
    win_sum = win_sum + item.sample;
    hist_mem[hist_wr_ptr] = item.sample;
    hist_wr_ptr = hist_wr_ptr + 1'b1;
    if (int'(hist_fill) < len) hist_fill = hist_fill + 1'b1;
    res = '0;
    res.window_full = (int'(hist_fill) >= len);
    if (res.window_full) begin
      // Average test without division: sum >= len * threshold.
      target = longint'(len) * longint'(thr_reg);
      if (longint'(win_sum) >= target) begin
        res.meets = 1'b1;
        if (match_tally != '1) match_tally = match_tally + 1'b1;
      end
    end
    res.match_count = match_tally;
    res.final_res   = item.last;
    if (item.last) restart_window();
    return res;
  endfunction

  function automatic void note_mismatch(string what, logic [CountW-1:0] want,
                                        logic [CountW-1:0] got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge, check a popped transaction against the
  // oldest prediction and predict for a pushed one. Both read pre-edge values.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expect_q.size() == 0) begin
          note_mismatch("unexpected result, match_count", '0, out_data.match_count);
        end else begin
          want = expect_q.pop_front();
          if (out_data.window_full !== want.window_full)
            note_mismatch("window_full", want.window_full, out_data.window_full);
          if (out_data.meets !== want.meets)
            note_mismatch("meets", want.meets, out_data.meets);
          if (out_data.match_count !== want.match_count)
            note_mismatch("match_count", want.match_count, out_data.match_count);
          if (out_data.final_res !== want.final_res)
            note_mismatch("final_res", want.final_res, out_data.final_res);
        end
      end
      if (push && !full) expect_q.push_back(advance_window(in_data));
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Pop side: a random idle gap before each transaction, or the long hold-off
  // when a test asks for one. pop stays high across back-to-back pops.
  // ---------------------------------------------------------------------------
  initial begin : pop_driver
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = rx_idle_on ? $urandom_range(0, 4) : 0;
      if (rx_hold > 0) begin
        gap     = rx_hold;
        rx_hold = 0;
      end
      if (gap > 0) begin
        @(negedge clk_i);
        pop <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  // ---------------------------------------------------------------------------
  // Push side and config helpers.
  // ---------------------------------------------------------------------------

  // One sample transaction; returns at the edge that accepts it with push
  // still high, so a following call with no gap keeps the stream back to back.
  task automatic send_sample(input logic [SampleBits-1:0] smp, input logic fin);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push    <= 1'b1;
    in_data <= '{sample: smp, last: fin};
    do @(posedge clk_i); while (full);
  endtask

  function automatic logic [SampleBits-1:0] pick_sample(smp_mode_e mode);
    int v;
    case (mode)
      SmpUniform: v = $urandom_range(0, 65535);
      SmpNearThr: begin
        v = int'(thr_reg) + int'($urandom_range(0, 2 * NearSpread)) - NearSpread;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
      end
      default: v = $urandom_range(0, 1) ? 65535 : 0;
    endcase
    return v[SampleBits-1:0];
  endfunction

  task automatic send_stream(input int n, input smp_mode_e mode, input bit with_last);
    for (int i = 0; i < n; i++) send_sample(pick_sample(mode), with_last && (i == n - 1));
  endtask

  // Stop pushing, let every predicted result come out, then wait DrainCycles.
  task automatic wait_drained();
    @(negedge clk_i);
    push <= 1'b0;
    while (expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Only called with the block drained; the predictor follows the write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      RegWindowLen: begin
        len_reg = val[CfgLenW-1:0];
        restart_window();
      end
      RegThreshold: thr_reg = val[ThrW-1:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: window of one, threshold zero, so every sample counts.
  task automatic test_reset_defaults();
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h8001, 1'b1);
  endtask

  // Threshold at both rails; equality at the top counts, one below does not.
  task automatic test_threshold_extremes();
    wait_drained();
    write_reg(RegThreshold, 16'hFFFF);
    write_reg(RegWindowLen, 16'd2);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFE, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    wait_drained();
    write_reg(RegThreshold, 16'h0000);
    write_reg(RegWindowLen, 16'd3);
    send_stream(4, SmpRails, 1'b1);
  endtask

  // Length zero acts as one, lengths past 1024 clamp, bits above the field drop.
  task automatic test_window_len_clamp();
    wait_drained();
    write_reg(RegThreshold, 16'd100);
    write_reg(RegWindowLen, 16'd0);
    send_sample(16'd100, 1'b0);
    send_sample(16'd99, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    wait_drained();
    write_reg(RegWindowLen, 16'hF802);   // masks to 2
    send_sample(16'd50, 1'b0);
    send_sample(16'd150, 1'b0);
    send_sample(16'd49, 1'b1);
    wait_drained();
    write_reg(RegWindowLen, 16'd1025);
    send_stream(2, SmpUniform, 1'b1);
    wait_drained();
    write_reg(RegWindowLen, 16'd1024);
    send_stream(2, SmpUniform, 1'b1);
  endtask

  // Writes to undecoded indexes leave the stream untouched.
  task automatic test_unknown_index();
    wait_drained();
    write_reg(RegWindowLen, 16'd3);
    send_stream(2, SmpUniform, 1'b0);
    wait_drained();
    write_reg(RegSpare2, 16'($urandom_range(0, 65535)));
    write_reg(RegSpare3, 16'($urandom_range(0, 65535)));
    send_stream(3, SmpUniform, 1'b1);
  endtask

  // last clears the window, count and pointer; the next stream starts fresh.
  // A length write mid-stream clears too; a threshold write does not.
  task automatic test_stream_restart();
    wait_drained();
    write_reg(RegThreshold, 16'd10);
    write_reg(RegWindowLen, 16'd3);
    send_stream(5, SmpNearThr, 1'b1);
    send_stream(4, SmpNearThr, 1'b0);
    wait_drained();
    write_reg(RegWindowLen, 16'd3);
    send_stream(3, SmpNearThr, 1'b0);
    wait_drained();
    write_reg(RegThreshold, 16'd12);
    send_stream(2, SmpNearThr, 1'b1);
  endtask

  // Full 1024 window: the history wraps and the oldest sample falls out.
  task automatic test_max_window();
    wait_drained();
    write_reg(RegWindowLen, 16'h07FF);   // 2047 clamps to 1024
    write_reg(RegThreshold, 16'd32768);
    send_stream(1100, SmpUniform, 1'b1);
  endtask

  // Long pop hold-off while pushes keep coming: the block fills and raises
  // full. Then the sender waits for every result before moving on.
  task automatic test_backpressure();
    wait_drained();
    write_reg(RegWindowLen, 16'd4);
    write_reg(RegThreshold, 16'd1000);
    tx_idle_on = 1'b0;
    rx_hold    = 80;
    send_stream(40, SmpNearThr, 1'b1);
    wait_drained();
    tx_idle_on = 1'b1;
  endtask

  // Random phases: new length and threshold each time, mostly streams long
  // enough to fill the window, some cut short, some left open and cleared by
  // the next length write, some with a threshold change in the middle.
  task automatic test_random();
    int        sent;
    int        phase_items;
    int        cnt;
    int        len_w;
    int        eff;
    int        n;
    int        split;
    int        r;
    bit        with_last;
    smp_mode_e mode;
    logic [ThrW-1:0] thr_w;
    sent = 0;
    while (sent < RandomItems) begin
      wait_drained();
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 19);
      if (r == 0)      len_w = 0;
      else if (r == 1) len_w = $urandom_range(1025, 2047);
      else if (r <= 3) len_w = $urandom_range(17, 200);
      else             len_w = $urandom_range(1, 16);
      // Random junk above the length field must be ignored.
      write_reg(RegWindowLen,
                CfgDataW'(len_w) | (CfgDataW'($urandom_range(0, 31)) << CfgLenW));
      r = $urandom_range(0, 9);
      thr_w = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      write_reg(RegThreshold, thr_w);
      r = $urandom_range(0, 9);
      mode = (r == 0) ? SmpRails : (r <= 2) ? SmpUniform : SmpNearThr;
      eff = eff_len();
      phase_items = $urandom_range(40, 150);
      cnt = 0;
      while (cnt < phase_items) begin
        if ($urandom_range(0, 4) == 0) n = $urandom_range(1, eff);
        else n = eff + $urandom_range(0, 2 * eff + 8);
        if (n > MaxStream) n = MaxStream;
        with_last = ($urandom_range(0, 9) != 0);
        if (n > 1 && $urandom_range(0, 7) == 0) begin
          split = $urandom_range(1, n - 1);
          send_stream(split, mode, 1'b0);
          wait_drained();
          write_reg(RegThreshold, 16'($urandom_range(0, 65535)));
          send_stream(n - split, mode, with_last);
        end else begin
          send_stream(n, mode, with_last);
        end
        cnt += n;
      end
      sent += cnt;
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_threshold_extremes();
    test_window_len_clamp();
    test_unknown_index();
    test_stream_restart();
    test_backpressure();
    test_max_window();
    test_random();

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (expect_q.size() != 0) begin
      mismatches++;
      $display("%0d predicted results never arrived", expect_q.size());
    end
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
